/* hdl/tgb_pkg.sv */
package tgb_pkg;

  // item function codes
  typedef enum logic [1:0] {
    FUNC_GLYPH = 2'd0,
    FUNC_FILL  = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_RDREQ,
    ST_DONE
  } state_t;

  // field and datapath widths
  localparam int unsigned NIB_W       = 4;
  localparam int unsigned GLYPH_COLS  = 8;
  localparam int unsigned PIX_W       = 9;   // x or y plus a counter, up to 509
  localparam int unsigned STRIDE_W    = 11;
  localparam int unsigned PROD_W      = PIX_W - 3 + STRIDE_W;
  localparam int unsigned BADDR_W     = 18;  // full pixel byte address before range check
  localparam int unsigned RD_ADDR_W   = 14;
  localparam int unsigned TILE_SHIFT  = 5;   // 32 bytes per tile
  localparam int unsigned TROW_SHIFT  = 2;   // 4 bytes per tile row
  localparam int unsigned PADDR_W     = 3;
  localparam int unsigned PDATA_W     = 32;

  localparam logic [STRIDE_W-1:0] STRIDE_RESET = 11'd256;

  // register index (paddr word select)
  localparam logic REG_STRIDE = 1'b0;

  // byte address of pixel (px, py) in the tiled window
  function automatic logic [BADDR_W-1:0] pixel_addr(
    input logic [PIX_W-1:0]    px,
    input logic [PIX_W-1:0]    py,
    input logic [STRIDE_W-1:0] stride
  );
    logic [PROD_W-1:0]  prod;
    logic [BADDR_W-1:0] tile_x;
    logic [BADDR_W-1:0] in_x;
    logic [BADDR_W-1:0] in_y;
    prod   = py[PIX_W-1:3] * stride;
    tile_x = BADDR_W'(px[PIX_W-1:3]) << TILE_SHIFT;
    in_x   = BADDR_W'(px[2:1]);
    in_y   = BADDR_W'(py[2:0]) << TROW_SHIFT;
    return tile_x + in_x + BADDR_W'(prod) + in_y;
  endfunction

endpackage

/* hdl/tgb_intf.sv */
// command channel
interface tgb_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [7:0]  x_pos;
  logic [7:0]  y_pos;
  logic [7:0]  width;
  logic [7:0]  height;
  logic [31:0] pixel_row;
  logic [3:0]  fill_value;
  logic [13:0] read_address;

  modport source (
    output valid, func, x_pos, y_pos, width, height, pixel_row, fill_value, read_address,
    input  ready
  );
  modport sink (
    input  valid, func, x_pos, y_pos, width, height, pixel_row, fill_value, read_address,
    output ready
  );
endinterface

// result channel
interface tgb_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       out_of_range;

  modport source (output valid, read_data, out_of_range, input ready);
  modport sink   (input valid, read_data, out_of_range, output ready);
endinterface

/* hdl/tiled_4bpp_glyph_blitter_top.sv */
// Tiled 4bpp blitter: holds MEM_BYTES of window memory as 8x8 tiles of 4-bit pixels
// (32 bytes per tile, even column in the low nibble, tile rows row_stride_bytes apart).
// A glyph-row beat merges the non-zero nibbles of up to eight pixels into one pixel row,
// a fill beat paints a width x height rectangle, a read beat returns one byte. Each beat
// gives exactly one result beat. One shared address unit (tile multiply-add) handles one
// pixel per cycle, and the window is stored as separate low/high nibble memories so each
// pixel is a single write with no read-modify-write. The block takes no new beat until
// the current one has produced its result. Pixels whose byte address is at or above
// MEM_BYTES are skipped and reported through out_of_range. The window memory has no
// reset; reading a byte never written returns whatever the RAM holds.
module tiled_4bpp_glyph_blitter_top import tgb_pkg::*; #(
  parameter int unsigned MEM_BYTES = 16384
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  tgb_cmd_if.sink            cmd,
  tgb_rsp_if.source          rsp
);

  localparam int unsigned AW = $clog2(MEM_BYTES);
  localparam logic [BADDR_W-1:0] MEM_LIMIT = BADDR_W'(MEM_BYTES);

  // config register
  logic [STRIDE_W-1:0] stride;

  // sequencer
  state_t state, state_next;
  logic   load_rsp;
  logic   step;

  // latched item
  func_t                func_q;
  logic [7:0]           x_q, y_q, w_q, h_q;
  logic [31:0]          pix_q;
  logic [NIB_W-1:0]     fv_q;
  logic [RD_ADDR_W-1:0] ra_q;

  // pixel counters
  logic [7:0] col, row;

  // write stage
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic             wr_hi;
  logic [NIB_W-1:0] wr_nib;

  logic       oor;
  logic [7:0] rd_byte;

  // result register
  logic       rsp_valid;
  logic [7:0] rsp_data;
  logic       rsp_oor;

  // window memory, split by nibble
  logic [NIB_W-1:0] mem_lo [MEM_BYTES];
  logic [NIB_W-1:0] mem_hi [MEM_BYTES];

  // address unit and per-pixel decode
  logic [PIX_W-1:0]   px, py;
  logic [BADDR_W-1:0] addr;
  logic [NIB_W-1:0]   cur_nib;
  logic               in_range, pix_active, last_col, last_row, last_pix;
  logic               accept, ra_in_range;
  logic [AW-1:0]      rd_addr;

  assign px         = PIX_W'(x_q) + PIX_W'(col);
  assign py         = PIX_W'(y_q) + PIX_W'(row);
  assign addr       = pixel_addr(px, py, stride);
  assign in_range   = addr < MEM_LIMIT;
  assign cur_nib    = (func_q == FUNC_FILL) ? fv_q : pix_q[col[2:0]*NIB_W +: NIB_W];
  assign pix_active = (func_q == FUNC_FILL) || (cur_nib != '0);
  assign last_col   = col == (w_q - 8'd1);
  assign last_row   = row == (h_q - 8'd1);
  assign last_pix   = last_col && ((func_q == FUNC_GLYPH) || last_row);

  assign accept      = cmd.valid && cmd.ready;
  assign ra_in_range = BADDR_W'(cmd.read_address) < MEM_LIMIT;
  assign rd_addr     = AW'(ra_q);

  // APB register port
  assign pready = 1'b1;
  assign prdata = (paddr[PADDR_W-1:2] == REG_STRIDE) ? PDATA_W'(stride) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      stride <= STRIDE_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[PADDR_W-1:2] == REG_STRIDE) begin
      stride <= pwdata[STRIDE_W-1:0];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (func_t'(cmd.func))
            FUNC_GLYPH: state_next = (cmd.width != '0) ? ST_RUN : ST_DONE;
            FUNC_FILL:  state_next = (cmd.width != '0 && cmd.height != '0) ? ST_RUN : ST_DONE;
            FUNC_READ:  state_next = ra_in_range ? ST_RDREQ : ST_DONE;
            default:    state_next = ST_DONE;
          endcase
        end
      end
      ST_RUN:   state_next = last_pix ? ST_DRAIN : ST_RUN;
      ST_DRAIN: state_next = ST_DONE;
      ST_RDREQ: state_next = ST_DONE;
      ST_DONE:  state_next = load_rsp ? ST_IDLE : ST_DONE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    cmd.ready = state == ST_IDLE;
    step      = state == ST_RUN;
    load_rsp  = (state == ST_DONE) && (!rsp_valid || rsp.ready);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // item capture
  always_ff @(posedge clk) begin
    if (accept) begin
      func_q <= func_t'(cmd.func);
      x_q    <= cmd.x_pos;
      y_q    <= cmd.y_pos;
      w_q    <= (func_t'(cmd.func) == FUNC_GLYPH && cmd.width > 8'(GLYPH_COLS)) ?
                8'(GLYPH_COLS) : cmd.width;
      h_q    <= cmd.height;
      pix_q  <= cmd.pixel_row;
      fv_q   <= cmd.fill_value;
      ra_q   <= cmd.read_address;
    end
  end

  // pixel counters, write stage and range flag
  always_ff @(posedge clk) begin
    if (rst) begin
      col   <= '0;
      row   <= '0;
      wr_en <= 1'b0;
      oor   <= 1'b0;
    end else begin
      wr_en <= step && pix_active && in_range;
      if (accept) begin
        oor <= (func_t'(cmd.func) == FUNC_READ) && !ra_in_range;
      end else if (step && pix_active && !in_range) begin
        oor <= 1'b1;
      end
      if (step) begin
        if (last_pix) begin
          col <= '0;
          row <= '0;
        end else if (func_q == FUNC_GLYPH || !last_col) begin
          col <= col + 8'd1;
        end else begin
          col <= '0;
          row <= row + 8'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    wr_addr <= addr[AW-1:0];
    wr_hi   <= px[0];
    wr_nib  <= cur_nib;
  end

  // window memory: nibble write, registered byte read
  always_ff @(posedge clk) begin
    if (wr_en && !wr_hi) mem_lo[wr_addr] <= wr_nib;
    if (wr_en && wr_hi)  mem_hi[wr_addr] <= wr_nib;
    if (state == ST_RDREQ) rd_byte <= {mem_hi[rd_addr], mem_lo[rd_addr]};
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load_rsp) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_rsp) begin
      rsp_data <= (func_q == FUNC_READ && !oor) ? rd_byte : '0;
      rsp_oor  <= oor;
    end
  end

  assign rsp.valid        = rsp_valid;
  assign rsp.read_data    = rsp_data;
  assign rsp.out_of_range = rsp_oor;

  // checks
  a_write_from_run: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> $past(state) == ST_RUN)
    else $error("memory write outside pixel walk");

  a_idle_counters: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> col == '0 && row == '0)
    else $error("pixel counters not cleared at end of item");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != ST_IDLE)
    else $error("accepted beat did not start work");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    load_rsp |=> rsp_valid && state == ST_IDLE)
    else $error("result beat lost");

endmodule

/* test/tb.sv */
module tb;
  import tgb_pkg::*;

  localparam int MEM_SIZE = 16384;
  localparam logic [PADDR_W-1:0] STRIDE_ADDR = PADDR_W'(REG_STRIDE) << 2;
  localparam bit KNOWN = 1'b1;  // row carries a hand-typed result
  localparam bit CALC  = 1'b0;  // row result comes from the window model
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    func_t       func;
    logic [7:0]  x_pos;
    logic [7:0]  y_pos;
    logic [7:0]  width;
    logic [7:0]  height;
    logic [31:0] pixel_row;
    logic [3:0]  fill_value;
    logic [13:0] read_address;
  } blit_cmd_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       out_of_range;
  } blit_rsp_t;

  typedef struct packed {
    logic [STRIDE_W-1:0] stride;
    blit_cmd_t           cmd;
    logic                typed;
    blit_rsp_t           rsp;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;
  logic psel, penable, pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata, prdata;
  logic pready;

  tgb_cmd_if cmd_if ();
  tgb_rsp_if rsp_if ();

  tiled_4bpp_glyph_blitter_top #(.MEM_BYTES(MEM_SIZE)) DUT (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cmd(cmd_if), .rsp(rsp_if)
  );

  // window image: byte contents, which nibbles were ever painted, fully painted bytes
  bit [7:0] window_img [MEM_SIZE];
  bit [1:0] nib_set [MEM_SIZE];
  bit       listed [MEM_SIZE];
  int       readable_addrs [$];
  logic [STRIDE_W-1:0] stride_now = STRIDE_RESET;

  blit_rsp_t window_replies [$];
  dir_row_t  dir_rows [$];
  int  bad_count = 0;
  bit  cmd_idle_en = 1'b1;
  bit  rsp_idle_en = 1'b1;
  int  hold_asked = 0;
  int  hold_taken = 0;
  int  hold_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void report_bad(string what);
    if (bad_count < 10) $display("mismatch: %s", what);
    bad_count++;
  endfunction

  // paint one nibble; returns 1 when the byte lies past the end of memory
  function automatic bit poke_nibble(int px, int py, logic [3:0] v);
    int a;
    a = ((px >> 3) << TILE_SHIFT) + ((px & 7) >> 1) + (py >> 3) * int'(stride_now)
      + ((py & 7) << TROW_SHIFT);
    if (a >= MEM_SIZE) return 1'b1;
    if (px & 1) window_img[a][7:4] = v;
    else window_img[a][3:0] = v;
    nib_set[a][px & 1] = 1'b1;
    if (nib_set[a] == 2'b11 && !listed[a]) begin
      listed[a] = 1'b1;
      readable_addrs.push_back(a);
    end
    return 1'b0;
  endfunction

  // apply one command to the window image and return the reply it owes
  function automatic blit_rsp_t blit_window(blit_cmd_t c);
    blit_rsp_t r;
    int cols;
    r = '0;
    case (c.func)
      FUNC_GLYPH: begin
        cols = (c.width > GLYPH_COLS) ? GLYPH_COLS : c.width;
        for (int k = 0; k < cols; k++)
          if (c.pixel_row[NIB_W*k +: NIB_W] != 4'h0)
            r.out_of_range |= poke_nibble(c.x_pos + k, c.y_pos,
                                          c.pixel_row[NIB_W*k +: NIB_W]);
      end
      FUNC_FILL: begin
        for (int row = 0; row < c.height; row++)
          for (int k = 0; k < c.width; k++)
            r.out_of_range |= poke_nibble(c.x_pos + k, c.y_pos + row, c.fill_value);
      end
      FUNC_READ: begin
        if (c.read_address < MEM_SIZE) r.read_data = window_img[c.read_address];
        else r.out_of_range = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  // all fields random, func left as the unused code
  function automatic blit_cmd_t noise_cmd();
    blit_cmd_t c;
    c.func         = FUNC_NONE;
    c.x_pos        = 8'($urandom_range(255));
    c.y_pos        = 8'($urandom_range(255));
    c.width        = 8'($urandom_range(255));
    c.height       = 8'($urandom_range(255));
    c.pixel_row    = $urandom;
    c.fill_value   = 4'($urandom_range(15));
    c.read_address = 14'($urandom_range(MEM_SIZE - 1));
    return c;
  endfunction

  function automatic void add_row(int s, func_t f, int x, int y, int w, int h,
                                  logic [31:0] pix, int fv, int ra,
                                  bit typed, int rd, bit oor);
    dir_row_t d;
    d.stride               = STRIDE_W'(s);
    d.cmd.func             = f;
    d.cmd.x_pos            = 8'(x);
    d.cmd.y_pos            = 8'(y);
    d.cmd.width            = 8'(w);
    d.cmd.height           = 8'(h);
    d.cmd.pixel_row        = pix;
    d.cmd.fill_value       = 4'(fv);
    d.cmd.read_address     = 14'(ra);
    d.typed                = typed;
    d.rsp.read_data        = 8'(rd);
    d.rsp.out_of_range     = oor;
    dir_rows.push_back(d);
  endfunction

  // one command beat; valid is left high so back-to-back beats need no re-raise
  task automatic send_cmd(blit_cmd_t c, bit typed, blit_rsp_t typed_rsp);
    blit_rsp_t pred;
    while (cmd_idle_en && $urandom_range(99) < 11) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_if.valid        <= 1'b1;
    cmd_if.func         <= c.func;
    cmd_if.x_pos        <= c.x_pos;
    cmd_if.y_pos        <= c.y_pos;
    cmd_if.width        <= c.width;
    cmd_if.height       <= c.height;
    cmd_if.pixel_row    <= c.pixel_row;
    cmd_if.fill_value   <= c.fill_value;
    cmd_if.read_address <= c.read_address;
    do @(posedge clk); while (!cmd_if.ready);
    pred = blit_window(c);
    window_replies.push_back(typed ? typed_rsp : pred);
  endtask

  // APB transfer to the stride register; caller drops psel afterwards
  task automatic apb_xfer(bit wr, logic [PDATA_W-1:0] wdata,
                          output logic [PDATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= STRIDE_ADDR;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
  endtask

  // drain the block, then rewrite and read back the stride
  task automatic set_stride(logic [STRIDE_W-1:0] s);
    logic [PDATA_W-1:0] got;
    cmd_if.valid <= 1'b0;
    while (window_replies.size() != 0) @(posedge clk);
    apb_xfer(1'b1, PDATA_W'(s), got);
    apb_xfer(1'b0, '0, got);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== PDATA_W'(s))
      report_bad($sformatf("stride readback exp %0d got %0d", s, got));
    stride_now = s;
  endtask

  // reply ready: random idling, plus long hold-offs on request
  always @(posedge clk) begin
    if (rst) begin
      rsp_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      rsp_if.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_taken != hold_asked) begin
      rsp_if.ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_taken <= hold_taken + 1;
    end else begin
      rsp_if.ready <= !(rsp_idle_en && $urandom_range(99) < 11);
    end
  end

  // reply checker
  always @(posedge clk) begin
    blit_rsp_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (window_replies.size() == 0) begin
        report_bad($sformatf("reply beat with none owed: data %h oor %b",
                             rsp_if.read_data, rsp_if.out_of_range));
      end else begin
        want = window_replies.pop_front();
        if (rsp_if.read_data !== want.read_data)
          report_bad($sformatf("read_data exp %h got %h", want.read_data, rsp_if.read_data));
        if (rsp_if.out_of_range !== want.out_of_range)
          report_bad($sformatf("out_of_range exp %b got %b",
                               want.out_of_range, rsp_if.out_of_range));
      end
    end
  end

  initial begin
    #50_000_000;
    $display("tb failed");
    $finish;
  end

  initial begin
    blit_cmd_t c;
    blit_rsp_t no_rsp;
    logic [PDATA_W-1:0] got;
    logic [7:0] gx, gy, gw;
    int sent, pick, rows;
    int phase_stride [6];

    phase_stride = '{32, 1024, 2047, 0, 512, 256};
    no_rsp = '0;
    rst                 <= 1'b1;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= STRIDE_ADDR;
    pwdata              <= '0;
    cmd_if.valid        <= 1'b0;
    cmd_if.func         <= FUNC_NONE;
    cmd_if.x_pos        <= '0;
    cmd_if.y_pos        <= '0;
    cmd_if.width        <= '0;
    cmd_if.height       <= '0;
    cmd_if.pixel_row    <= '0;
    cmd_if.fill_value   <= '0;
    cmd_if.read_address <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // stride comes out of reset at its default
    apb_xfer(1'b0, '0, got);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== PDATA_W'(STRIDE_RESET))
      report_bad($sformatf("stride after reset exp %0d got %0d", STRIDE_RESET, got));

    //      stride func        x    y    w    h    pixel_row     fv   addr   src    data oor
    add_row(256,  FUNC_FILL,  0,   0,   255, 255, 32'h0,        'hA, 0,     KNOWN, 'h00, 0);
    add_row(256,  FUNC_READ,  0,   0,   0,   0,   32'h0,        0,   0,     KNOWN, 'hAA, 0);
    add_row(256,  FUNC_GLYPH, 0,   0,   8,   0,   32'h12345670, 0,   0,     CALC,  0,    0);
    add_row(256,  FUNC_READ,  0,   0,   0,   0,   32'h0,        0,   0,     CALC,  0,    0);
    add_row(256,  FUNC_READ,  0,   0,   0,   0,   32'h0,        0,   1,     CALC,  0,    0);
    add_row(256,  FUNC_GLYPH, 250, 10,  255, 255, 32'hFFFFFFFF, 'hF, 16383, CALC,  0,    0);
    add_row(256,  FUNC_READ,  0,   0,   0,   0,   32'h0,        0,   1257,  CALC,  0,    0);
    add_row(256,  FUNC_GLYPH, 3,   5,   0,   7,   32'hFFFFFFFF, 0,   0,     KNOWN, 'h00, 0);
    add_row(256,  FUNC_FILL,  10,  10,  0,   9,   32'h0,        'hF, 0,     KNOWN, 'h00, 0);
    add_row(256,  FUNC_FILL,  10,  10,  9,   0,   32'h0,        'hF, 0,     KNOWN, 'h00, 0);
    add_row(256,  FUNC_NONE,  255, 255, 255, 255, 32'hFFFFFFFF, 'hF, 16383, KNOWN, 'h00, 0);
    add_row(256,  FUNC_FILL,  100, 20,  20,  12,  32'h0,        0,   0,     CALC,  0,    0);
    add_row(256,  FUNC_READ,  0,   0,   0,   0,   32'h0,        0,   626,   CALC,  0,    0);
    add_row(1024, FUNC_FILL,  248, 120, 8,   8,   32'h0,        5,   0,     KNOWN, 'h00, 0);
    add_row(1024, FUNC_READ,  0,   0,   0,   0,   32'h0,        0,   16383, KNOWN, 'h55, 0);
    add_row(1024, FUNC_GLYPH, 255, 255, 8,   0,   32'hFFFFFFFF, 0,   0,     KNOWN, 'h00, 1);
    add_row(1024, FUNC_GLYPH, 255, 255, 8,   0,   32'h0,        0,   0,     KNOWN, 'h00, 0);
    add_row(1024, FUNC_FILL,  255, 255, 255, 2,   32'h0,        7,   0,     KNOWN, 'h00, 1);
    add_row(32,   FUNC_FILL,  0,   0,   8,   8,   32'h0,        3,   0,     CALC,  0,    0);
    add_row(32,   FUNC_READ,  0,   0,   0,   0,   32'h0,        0,   0,     KNOWN, 'h33, 0);
    add_row(2047, FUNC_GLYPH, 4,   64,  8,   0,   32'h87654321, 0,   0,     CALC,  0,    0);
    add_row(2047, FUNC_READ,  0,   0,   0,   0,   32'h0,        0,   16379, CALC,  0,    0);
    add_row(0,    FUNC_FILL,  0,   200, 4,   4,   32'h0,        9,   0,     CALC,  0,    0);
    add_row(0,    FUNC_READ,  0,   0,   0,   0,   32'h0,        0,   0,     KNOWN, 'h99, 0);

    // directed rows; stride changes only with the block drained
    foreach (dir_rows[i]) begin
      if (dir_rows[i].stride != stride_now) set_stride(dir_rows[i].stride);
      send_cmd(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].rsp);
    end

    // random phases, one stride each
    phase_stride[4] = $urandom_range(33, 1023);
    for (int ph = 0; ph < 6; ph++) begin
      set_stride(STRIDE_W'(phase_stride[ph]));
      cmd_idle_en = (ph != 3);
      rsp_idle_en <= (ph != 3);
      if (ph == 1) hold_asked <= hold_asked + 1;
      sent = 0;
      while (sent < 92) begin
        pick = $urandom_range(99);
        c = noise_cmd();
        if (pick < 35) begin
          // multi-row glyph at one spot, fresh ink per row
          rows = $urandom_range(1, 8);
          gx = c.x_pos;
          gy = c.y_pos;
          gw = ($urandom_range(9) < 7) ? 8'd8 : 8'($urandom_range(15));
          repeat (rows) begin
            c = noise_cmd();
            c.func  = FUNC_GLYPH;
            c.x_pos = gx;
            c.y_pos = gy;
            c.width = gw;
            for (int k = 0; k < GLYPH_COLS; k++)
              c.pixel_row[NIB_W*k +: NIB_W] =
                ($urandom_range(3) == 0) ? 4'h0 : 4'($urandom_range(1, 15));
            send_cmd(c, CALC, no_rsp);
            sent++;
            gy++;
          end
        end else if (pick < 60) begin
          // mostly small rectangles, now and then a wide one
          c.func = FUNC_FILL;
          if ($urandom_range(24) == 0) begin
            c.width  = 8'($urandom_range(255));
            c.height = 8'($urandom_range(12));
          end else begin
            c.width  = 8'($urandom_range(16));
            c.height = 8'($urandom_range(16));
          end
          send_cmd(c, CALC, no_rsp);
          sent++;
        end else if (pick < 92) begin
          // reads only touch bytes whose both nibbles were painted
          c.func = FUNC_READ;
          c.read_address =
            14'(readable_addrs[$urandom_range(readable_addrs.size() - 1)]);
          send_cmd(c, CALC, no_rsp);
          sent++;
        end else begin
          send_cmd(c, CALC, no_rsp);
          sent++;
        end
      end
    end

    // wind down
    cmd_if.valid <= 1'b0;
    while (window_replies.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (bad_count == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

endmodule

/* sim.f */
hdl/tgb_pkg.sv
hdl/tgb_intf.sv
hdl/tiled_4bpp_glyph_blitter_top.sv
test/tb.sv
